FILE: hdl/ole_pkg.sv
// ----------------------------------------------------------------------------
// Ordered list engine package
// Transaction types, request codes and the command and status bundles that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package ole_pkg;

   localparam int VALUE_W  = 32;
   localparam int POS_IN_W = 6;
   localparam int POS_W    = 5;
   localparam int COUNT_W  = 6;
   localparam int OP_W     = 3;

   // Request codes; the one code left over is ignored by the engine.
   typedef enum logic [OP_W-1:0] {
      OP_HEAD   = 3'd0,
      OP_TAIL   = 3'd1,
      OP_AT     = 3'd2,
      OP_READ   = 3'd3,
      OP_REMOVE = 3'd4,
      OP_FIND   = 3'd5,
      OP_CLEAR  = 3'd6
   } op_code_type;

   typedef struct packed {
      logic [OP_W-1:0]           req_type;
      logic signed [VALUE_W-1:0] value_in;
      logic [POS_IN_W-1:0]       position_in;
   } req_item_type;

   typedef struct packed {
      logic                      ok;
      logic signed [VALUE_W-1:0] value_out;
      logic [POS_W-1:0]          position_out;
      logic [COUNT_W-1:0]        count_out;
      logic                      is_empty;
   } rsp_item_type;

   typedef enum logic [1:0] {
      TGT_INPUT = 2'd0,
      TGT_ZERO  = 2'd1,
      TGT_COUNT = 2'd2
   } tgt_sel_type;

   typedef enum logic [2:0] {
      CUR_HOLD  = 3'd0,
      CUR_ZERO  = 3'd1,
      CUR_COUNT = 3'd2,
      CUR_TGT   = 3'd3,
      CUR_INC   = 3'd4,
      CUR_DEC   = 3'd5
   } cur_op_type;

   typedef enum logic [1:0] {
      CNT_HOLD  = 2'd0,
      CNT_INC   = 2'd1,
      CNT_DEC   = 2'd2,
      CNT_CLEAR = 2'd3
   } cnt_op_type;

   typedef enum logic [1:0] {
      RD_CUR  = 2'd0,
      RD_PREV = 2'd1,
      RD_NEXT = 2'd2
   } rd_sel_type;

   typedef enum logic {
      WR_SHIFT = 1'b0,
      WR_VALUE = 1'b1
   } wr_src_type;

   typedef struct packed {
      logic        load_req;
      tgt_sel_type tgt_sel;
      cur_op_type  cur_op;
      cnt_op_type  cnt_op;
      logic        rd_en;
      rd_sel_type  rd_sel;
      logic        wr_en;
      wr_src_type  wr_src;
      logic        clear_res;
      logic        set_ok;
      logic        take_value;
      logic        take_pos;
   } dp_cmd_type;

   typedef struct packed {
      logic full;
      logic tgt_gt_count;
      logic tgt_ge_count;
      logic cur_eq_tgt;
      logic cur_eq_count;
      logic next_lt_count;
      logic match;
   } dp_status_type;

endpackage

FILE: hdl/ole_datapath.sv
// ----------------------------------------------------------------------------
// Ordered list datapath
// Entry memory, count, cursor, target position and result registers.
// ----------------------------------------------------------------------------
module ole_datapath #(
   parameter int CAPACITY = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ole_pkg::req_item_type req_item,
   input  ole_pkg::dp_cmd_type   cmd,
   output ole_pkg::dp_status_type status,
   output ole_pkg::rsp_item_type rsp_item
);

   localparam int AW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW      = $clog2(CAPACITY + 1);
   localparam int PW      = (CW > ole_pkg::POS_IN_W) ? CW : ole_pkg::POS_IN_W;
   localparam int VALUE_W = ole_pkg::VALUE_W;
   localparam int POS_W   = ole_pkg::POS_W;
   localparam int COUNT_W = ole_pkg::COUNT_W;

   logic signed [VALUE_W-1:0] mem [CAPACITY];

   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic [PW-1:0]             tgt_ff, tgt_in;
   logic [CW-1:0]             cur_ff, cur_in;
   logic [CW-1:0]             count_ff, count_in;
   logic signed [VALUE_W-1:0] rd_data_ff;
   logic                      ok_ff, ok_in;
   logic signed [VALUE_W-1:0] value_out_ff, value_out_in;
   logic [POS_W-1:0]          pos_out_ff, pos_out_in;

   logic [AW-1:0]             rd_addr;
   logic [AW-1:0]             wr_addr;
   logic signed [VALUE_W-1:0] wr_data;

   // Memory addressing around the cursor
   always_comb begin
      unique case (cmd.rd_sel)
         ole_pkg::RD_PREV: rd_addr = AW'(cur_ff - CW'(1));
         ole_pkg::RD_NEXT: rd_addr = AW'(cur_ff + CW'(1));
         default:          rd_addr = AW'(cur_ff);
      endcase
      wr_addr = AW'(cur_ff);
      wr_data = (cmd.wr_src == ole_pkg::WR_VALUE) ? value_ff : rd_data_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Request capture, cursor and result updates
   always_comb begin
      value_in     = value_ff;
      tgt_in       = tgt_ff;
      if (cmd.load_req) begin
         value_in = req_item.value_in;
         unique case (cmd.tgt_sel)
            ole_pkg::TGT_ZERO:  tgt_in = '0;
            ole_pkg::TGT_COUNT: tgt_in = PW'(count_ff);
            default:            tgt_in = PW'(req_item.position_in);
         endcase
      end

      unique case (cmd.cur_op)
         ole_pkg::CUR_ZERO:  cur_in = '0;
         ole_pkg::CUR_COUNT: cur_in = count_ff;
         ole_pkg::CUR_TGT:   cur_in = CW'(tgt_ff);
         ole_pkg::CUR_INC:   cur_in = cur_ff + CW'(1);
         ole_pkg::CUR_DEC:   cur_in = cur_ff - CW'(1);
         default:            cur_in = cur_ff;
      endcase

      unique case (cmd.cnt_op)
         ole_pkg::CNT_INC:   count_in = count_ff + CW'(1);
         ole_pkg::CNT_DEC:   count_in = count_ff - CW'(1);
         ole_pkg::CNT_CLEAR: count_in = '0;
         default:            count_in = count_ff;
      endcase

      ok_in        = ok_ff;
      value_out_in = value_out_ff;
      pos_out_in   = pos_out_ff;
      if (cmd.clear_res) begin
         ok_in        = 1'b0;
         value_out_in = '0;
         pos_out_in   = '0;
      end
      if (cmd.set_ok) begin
         ok_in = 1'b1;
      end
      if (cmd.take_value) begin
         value_out_in = rd_data_ff;
      end
      if (cmd.take_pos) begin
         pos_out_in = POS_W'(cur_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff     <= value_in;
      tgt_ff       <= tgt_in;
      cur_ff       <= cur_in;
      ok_ff        <= ok_in;
      value_out_ff <= value_out_in;
      pos_out_ff   <= pos_out_in;
   end

   // Status back to the controller
   always_comb begin
      status.full          = (count_ff == CW'(CAPACITY));
      status.tgt_gt_count  = (tgt_ff > PW'(count_ff));
      status.tgt_ge_count  = (tgt_ff >= PW'(count_ff));
      status.cur_eq_tgt    = (PW'(cur_ff) == tgt_ff);
      status.cur_eq_count  = (cur_ff == count_ff);
      status.next_lt_count = (({1'b0, cur_ff} + (CW + 1)'(1)) < {1'b0, count_ff});
      status.match         = (rd_data_ff == value_ff);
   end

   always_comb begin
      rsp_item.ok           = ok_ff;
      rsp_item.value_out    = value_out_ff;
      rsp_item.position_out = pos_out_ff;
      rsp_item.count_out    = COUNT_W'(count_ff);
      rsp_item.is_empty     = (count_ff == '0);
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> (cur_ff < CW'(CAPACITY)))
      else $error("entry write beyond capacity");
`endif

endmodule

FILE: hdl/ole_ctrl.sv
// ----------------------------------------------------------------------------
// Ordered list controller
// Sequences shifts, reads and searches over the entry memory.
// ----------------------------------------------------------------------------
module ole_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  ole_pkg::req_item_type  req_item,
   input  ole_pkg::dp_status_type status,
   output ole_pkg::dp_cmd_type    cmd,
   output logic                   busy,
   output logic                   rsp_strobe
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_UP_READ,
      ST_UP_WRITE,
      ST_TAKE_READ,
      ST_TAKE,
      ST_DN_READ,
      ST_DN_WRITE,
      ST_FIND_READ,
      ST_FIND_TEST
   } state_type;

   state_type                  state_ff, state_in;
   logic [ole_pkg::OP_W-1:0]   op_ff, op_in;
   logic                       busy_ff, busy_in;
   logic                       strobe_ff, strobe_in;
   logic                       finish;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      op_in    = op_ff;
      finish   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               op_in        = req_item.req_type;
               if (req_item.req_type == ole_pkg::OP_HEAD) begin
                  cmd.tgt_sel = ole_pkg::TGT_ZERO;
               end else if (req_item.req_type == ole_pkg::OP_TAIL) begin
                  cmd.tgt_sel = ole_pkg::TGT_COUNT;
               end else begin
                  cmd.tgt_sel = ole_pkg::TGT_INPUT;
               end
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.clear_res = 1'b1;
            unique case (op_ff)
               ole_pkg::OP_HEAD, ole_pkg::OP_TAIL, ole_pkg::OP_AT: begin
                  if (status.full || status.tgt_gt_count) begin
                     finish = 1'b1;
                  end else begin
                     cmd.cur_op = ole_pkg::CUR_COUNT;
                     state_in   = ST_UP_READ;
                  end
               end
               ole_pkg::OP_READ, ole_pkg::OP_REMOVE: begin
                  if (status.tgt_ge_count) begin
                     finish = 1'b1;
                  end else begin
                     cmd.cur_op = ole_pkg::CUR_TGT;
                     state_in   = ST_TAKE_READ;
                  end
               end
               ole_pkg::OP_FIND: begin
                  cmd.cur_op = ole_pkg::CUR_ZERO;
                  state_in   = ST_FIND_READ;
               end
               ole_pkg::OP_CLEAR: begin
                  cmd.cnt_op = ole_pkg::CNT_CLEAR;
                  cmd.set_ok = 1'b1;
                  finish     = 1'b1;
               end
               default: begin
                  finish = 1'b1;
               end
            endcase
         end
         ST_UP_READ: begin
            if (status.cur_eq_tgt) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_src = ole_pkg::WR_VALUE;
               cmd.cnt_op = ole_pkg::CNT_INC;
               cmd.set_ok = 1'b1;
               finish     = 1'b1;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = ole_pkg::RD_PREV;
               state_in   = ST_UP_WRITE;
            end
         end
         ST_UP_WRITE: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_src = ole_pkg::WR_SHIFT;
            cmd.cur_op = ole_pkg::CUR_DEC;
            state_in   = ST_UP_READ;
         end
         ST_TAKE_READ: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = ole_pkg::RD_CUR;
            state_in   = ST_TAKE;
         end
         ST_TAKE: begin
            cmd.take_value = 1'b1;
            cmd.set_ok     = 1'b1;
            if (op_ff == ole_pkg::OP_REMOVE) begin
               state_in = ST_DN_READ;
            end else begin
               finish = 1'b1;
            end
         end
         ST_DN_READ: begin
            if (status.next_lt_count) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = ole_pkg::RD_NEXT;
               state_in   = ST_DN_WRITE;
            end else begin
               cmd.cnt_op = ole_pkg::CNT_DEC;
               finish     = 1'b1;
            end
         end
         ST_DN_WRITE: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_src = ole_pkg::WR_SHIFT;
            cmd.cur_op = ole_pkg::CUR_INC;
            state_in   = ST_DN_READ;
         end
         ST_FIND_READ: begin
            if (status.cur_eq_count) begin
               finish = 1'b1;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = ole_pkg::RD_CUR;
               state_in   = ST_FIND_TEST;
            end
         end
         ST_FIND_TEST: begin
            if (status.match) begin
               cmd.set_ok   = 1'b1;
               cmd.take_pos = 1'b1;
               finish       = 1'b1;
            end else begin
               cmd.cur_op = ole_pkg::CUR_INC;
               state_in   = ST_FIND_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (finish) begin
         state_in = ST_IDLE;
      end
      busy_in   = (state_in != ST_IDLE);
      strobe_in = finish;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         op_ff     <= '0;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         op_ff     <= op_in;
         busy_ff   <= busy_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

`ifndef SYNTHESIS
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> !busy_ff)
      else $error("result strobed while busy");

   a_busy_ends_with_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> strobe_ff)
      else $error("transaction ended without a result");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |=> !strobe_ff)
      else $error("result strobe held for two cycles");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (start && !busy_ff) |=> (busy_ff && state_ff == ST_DECODE))
      else $error("accepted transaction did not start");
`endif

endmodule

FILE: hdl/ordered_list_engine.sv
// ----------------------------------------------------------------------------
// Ordered list engine
// Positional list of up to CAPACITY signed values held in a single-port-write,
// registered-read memory, with head, tail and positional insert, read,
// remove, find and clear.
// ----------------------------------------------------------------------------
// From accept to result strobe: clear and rejected requests finish at decode; read
// takes the entry at the position; insert and remove add one shift step per entry
// moved, and find adds one read-then-test step per entry scanned.
// One transaction in flight: busy holds from accept to the result strobe, set by
// the read-then-write shift step and the read-then-test search step.
// Synchronous active-high reset empties the list at once; no clearing pass.
// Results are strobed for one cycle and cannot be stalled by the receiver.
module ordered_list_engine #(
   parameter int CAPACITY = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  ole_pkg::req_item_type req_item,
   output logic                  rsp_strobe,
   output ole_pkg::rsp_item_type rsp_item
);

   // Command and status bundles between the sequencer and the datapath
   ole_pkg::dp_cmd_type    cmd;
   ole_pkg::dp_status_type status;

   // Controller: decode each transaction and walk the memory one step at a
   // time. Insert shifts entries up from the tail toward the target, remove
   // shifts them down from the target toward the tail, and find scans from
   // the head until a match or the end of the list.
   ole_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_item   (req_item),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   // Datapath: hold the entries, the count, the cursor and the result fields.
   // Result fields are stable from the strobe cycle until the next
   // transaction is decoded, so a new request may be accepted while the
   // previous result is on the ports.
   ole_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .status   (status),
      .rsp_item (rsp_item)
   );

endmodule
